// ===== rtl/core/i2cdw_pkg.sv =====
// i2cdw_pkg: shared types and constants for the I2C display write master.
// Used by the sequencer and the top level.
package i2cdw_pkg;

  localparam logic [7:0]  SlaveAddrRst  = 8'h78;
  localparam logic [15:0] PhaseTicksRst = 16'd1;
  localparam logic [7:0]  CtrlData      = 8'h40;
  localparam logic [7:0]  CtrlCmd       = 8'h00;
  localparam int          CfgDataW      = 16;
  localparam int          CfgIdxW       = 1;

  localparam logic [CfgIdxW-1:0] CfgSlaveAddr  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgPhaseTicks = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_A1, ST_A2, ST_A3, ST_A4, ST_A5,
    ST_B0, ST_B1, ST_B2, ST_B3, ST_B4,
    ST_K0, ST_K1, ST_K2, ST_K3, ST_K4, ST_K5,
    ST_P0, ST_P1, ST_P2, ST_P3
  } step_t;

  typedef struct packed {
    logic       op;
    logic       is_data;
    logic [7:0] payload;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic scl;
    logic sda_out;
    logic sda_drive;
    logic busy_res;
    logic done_res;
    logic addr_nack;
  } out_item_t;

endpackage

// ===== rtl/core/i2cdw_if.sv =====
// i2cdw_if: valid/ready channel interfaces for request/tick beats and pin results.
// No package dependency.
interface i2cdw_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic       is_data;
  logic [7:0] payload;
  logic       sda_in;

  modport source (output valid, output op, output is_data, output payload,
                  output sda_in, input ready);
  modport sink   (input valid, input op, input is_data, input payload,
                  input sda_in, output ready);
endinterface

interface i2cdw_out_if;
  logic valid;
  logic ready;
  logic scl;
  logic sda_out;
  logic sda_drive;
  logic busy_res;
  logic done_res;
  logic addr_nack;

  modport source (output valid, output scl, output sda_out, output sda_drive,
                  output busy_res, output done_res, output addr_nack, input ready);
  modport sink   (input valid, input scl, input sda_out, input sda_drive,
                  input busy_res, input done_res, input addr_nack, output ready);
endinterface

// ===== rtl/core/i2cdw_seq.sv =====
// i2cdw_seq: frame sequencer state, configuration registers and per-beat update.
// Depends on i2cdw_pkg.
module i2cdw_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [i2cdw_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [i2cdw_pkg::CfgDataW-1:0] cfg_data,
  input  logic                           step_en,
  input  i2cdw_pkg::in_item_t            item,
  output i2cdw_pkg::out_item_t           res
);

  logic [7:0]          slave_addr_r;
  logic [15:0]         phase_ticks_r;
  i2cdw_pkg::step_t    step_r, step_nxt;
  logic [3:0]          bit_cnt_r, bit_cnt_nxt;
  logic [1:0]          byte_idx_r, byte_idx_nxt;
  logic [7:0]          shift_r, shift_nxt;
  logic [15:0]         delay_r, delay_nxt;
  logic [7:0]          held_pl_r, held_pl_nxt;
  logic                held_dat_r, held_dat_nxt;
  logic                scl_r, scl_nxt;
  logic                sda_r, sda_nxt;
  logic                drv_r, drv_nxt;
  logic                nack_r, nack_nxt;
  logic                done;
  logic [15:0]         limit;
  logic [15:0]         delay_inc;
  logic [1:0]          next_byte;

  function automatic logic [7:0] pick_byte(input logic [1:0] idx, input logic [7:0] addr,
                                           input logic dat, input logic [7:0] pl);
    logic [7:0] b;
    if (idx == 2'd0) begin
      b = addr;
    end else if (idx == 2'd1) begin
      b = dat ? i2cdw_pkg::CtrlData : i2cdw_pkg::CtrlCmd;
    end else begin
      b = pl;
    end
    return b;
  endfunction

  assign limit     = (phase_ticks_r == 16'd0) ? 16'd1 : phase_ticks_r;
  assign delay_inc = delay_r + 16'd1;
  assign next_byte = byte_idx_r + 2'd1;

  always_comb begin
    step_nxt     = step_r;
    bit_cnt_nxt  = bit_cnt_r;
    byte_idx_nxt = byte_idx_r;
    shift_nxt    = shift_r;
    delay_nxt    = delay_r;
    held_pl_nxt  = held_pl_r;
    held_dat_nxt = held_dat_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    drv_nxt      = drv_r;
    nack_nxt     = nack_r;
    done         = 1'b0;
    if (step_r == i2cdw_pkg::ST_IDLE) begin
      if (item.op) begin
        held_pl_nxt  = item.payload;
        held_dat_nxt = item.is_data;
        nack_nxt     = 1'b0;
        bit_cnt_nxt  = 4'd0;
        byte_idx_nxt = 2'd0;
        delay_nxt    = 16'd0;
        step_nxt     = i2cdw_pkg::ST_A1;
      end
    end else if (!item.op) begin
      if (delay_inc < limit) begin
        delay_nxt = delay_inc;
      end else begin
        delay_nxt = 16'd0;
        case (step_r)
          i2cdw_pkg::ST_A1: step_nxt = i2cdw_pkg::ST_A2;
          i2cdw_pkg::ST_A2: begin
            sda_nxt  = 1'b0;
            step_nxt = i2cdw_pkg::ST_A3;
          end
          i2cdw_pkg::ST_A3: step_nxt = i2cdw_pkg::ST_A4;
          i2cdw_pkg::ST_A4: begin
            scl_nxt  = 1'b0;
            step_nxt = i2cdw_pkg::ST_A5;
          end
          i2cdw_pkg::ST_A5: begin
            byte_idx_nxt = 2'd0;
            shift_nxt    = slave_addr_r;
            bit_cnt_nxt  = 4'd0;
            step_nxt     = i2cdw_pkg::ST_B0;
          end
          i2cdw_pkg::ST_B0: begin
            sda_nxt   = shift_r[7];
            shift_nxt = {shift_r[6:0], 1'b0};
            step_nxt  = i2cdw_pkg::ST_B1;
          end
          i2cdw_pkg::ST_B1: begin
            scl_nxt  = 1'b1;
            step_nxt = i2cdw_pkg::ST_B2;
          end
          i2cdw_pkg::ST_B2: begin
            scl_nxt  = 1'b0;
            step_nxt = i2cdw_pkg::ST_B3;
          end
          i2cdw_pkg::ST_B3: begin
            sda_nxt  = 1'b0;
            step_nxt = i2cdw_pkg::ST_B4;
          end
          i2cdw_pkg::ST_B4: begin
            if (bit_cnt_r < 4'd7) begin
              bit_cnt_nxt = bit_cnt_r + 4'd1;
              step_nxt    = i2cdw_pkg::ST_B0;
            end else begin
              step_nxt = i2cdw_pkg::ST_K0;
            end
          end
          i2cdw_pkg::ST_K0: begin
            drv_nxt  = 1'b0;
            step_nxt = i2cdw_pkg::ST_K1;
          end
          i2cdw_pkg::ST_K1: begin
            scl_nxt  = 1'b1;
            step_nxt = i2cdw_pkg::ST_K2;
          end
          i2cdw_pkg::ST_K2: begin
            if (byte_idx_r == 2'd0) begin
              nack_nxt = item.sda_in;
            end
            step_nxt = i2cdw_pkg::ST_K3;
          end
          i2cdw_pkg::ST_K3: begin
            scl_nxt  = 1'b0;
            step_nxt = i2cdw_pkg::ST_K4;
          end
          i2cdw_pkg::ST_K4: begin
            drv_nxt  = 1'b1;
            step_nxt = i2cdw_pkg::ST_K5;
          end
          i2cdw_pkg::ST_K5: begin
            if ((byte_idx_r == 2'd0 && nack_r) || byte_idx_r >= 2'd2) begin
              step_nxt = i2cdw_pkg::ST_P0;
            end else begin
              byte_idx_nxt = next_byte;
              shift_nxt    = pick_byte(next_byte, slave_addr_r, held_dat_r, held_pl_r);
              bit_cnt_nxt  = 4'd0;
              step_nxt     = i2cdw_pkg::ST_B0;
            end
          end
          i2cdw_pkg::ST_P0: begin
            scl_nxt  = 1'b1;
            step_nxt = i2cdw_pkg::ST_P1;
          end
          i2cdw_pkg::ST_P1: begin
            sda_nxt  = 1'b1;
            step_nxt = i2cdw_pkg::ST_P2;
          end
          i2cdw_pkg::ST_P2: step_nxt = i2cdw_pkg::ST_P3;
          i2cdw_pkg::ST_P3: begin
            step_nxt = i2cdw_pkg::ST_IDLE;
            done     = 1'b1;
          end
          default: step_nxt = i2cdw_pkg::ST_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    res.scl       = scl_nxt;
    res.sda_out   = sda_nxt;
    res.sda_drive = drv_nxt;
    res.busy_res  = (step_nxt != i2cdw_pkg::ST_IDLE);
    res.done_res  = done;
    res.addr_nack = done & nack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r  <= i2cdw_pkg::SlaveAddrRst;
      phase_ticks_r <= i2cdw_pkg::PhaseTicksRst;
      step_r        <= i2cdw_pkg::ST_IDLE;
      bit_cnt_r     <= 4'd0;
      byte_idx_r    <= 2'd0;
      shift_r       <= 8'd0;
      delay_r       <= 16'd0;
      held_pl_r     <= 8'd0;
      held_dat_r    <= 1'b0;
      scl_r         <= 1'b1;
      sda_r         <= 1'b1;
      drv_r         <= 1'b1;
      nack_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          i2cdw_pkg::CfgSlaveAddr:  slave_addr_r  <= cfg_data[7:0];
          i2cdw_pkg::CfgPhaseTicks: phase_ticks_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (step_en) begin
        step_r     <= step_nxt;
        bit_cnt_r  <= bit_cnt_nxt;
        byte_idx_r <= byte_idx_nxt;
        shift_r    <= shift_nxt;
        delay_r    <= delay_nxt;
        held_pl_r  <= held_pl_nxt;
        held_dat_r <= held_dat_nxt;
        scl_r      <= scl_nxt;
        sda_r      <= sda_nxt;
        drv_r      <= drv_nxt;
        nack_r     <= nack_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/i2c_display_write_master_unit.sv =====
// i2c_display_write_master_unit: top level, input beat register, sequencer, result register.
// Depends on i2cdw_pkg, i2cdw_if and i2cdw_seq.
//
//   channel  | dir | handshake     | beat content
//   in_bus   | in  | valid/ready   | op, is_data, payload, sda_in
//   out_bus  | out | valid/ready   | scl, sda_out, sda_drive, busy_res, done_res, addr_nack
//   cfg_*    | in  | write enable  | cfg_idx selects register, cfg_data value
//
// One beat per clock while out_bus is not stalled; a beat's result passes through the input
// register, then the sequencer update into the result register.
// Reset is synchronous on rst_n low: pins idle high and driven, sequencer idle.
// A stalled result holds in the result register while one more beat waits in the
// input register; in_bus.ready drops only when both are full.
module i2c_display_write_master_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  i2cdw_in_if.sink                       in_bus,
  i2cdw_out_if.source                    out_bus,
  input  logic                           cfg_we,
  input  logic [i2cdw_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [i2cdw_pkg::CfgDataW-1:0] cfg_data
);

  logic                 s1_v_r;
  i2cdw_pkg::in_item_t  s1_item_r;
  logic                 out_v_r;
  i2cdw_pkg::out_item_t out_item_r;
  i2cdw_pkg::out_item_t res;
  logic                 adv;
  logic                 in_fire;

  assign adv          = s1_v_r && (!out_v_r || out_bus.ready);
  assign in_bus.ready = !s1_v_r || adv;
  assign in_fire      = in_bus.valid && in_bus.ready;

  i2cdw_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .step_en  (adv),
    .item     (s1_item_r),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_bus.ready) begin
        s1_v_r <= in_bus.valid;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= '{op: in_bus.op, is_data: in_bus.is_data,
                     payload: in_bus.payload, sda_in: in_bus.sda_in};
    end
    if (adv) begin
      out_item_r <= res;
    end
  end

  assign out_bus.valid     = out_v_r;
  assign out_bus.scl       = out_item_r.scl;
  assign out_bus.sda_out   = out_item_r.sda_out;
  assign out_bus.sda_drive = out_item_r.sda_drive;
  assign out_bus.busy_res  = out_item_r.busy_res;
  assign out_bus.done_res  = out_item_r.done_res;
  assign out_bus.addr_nack = out_item_r.addr_nack;

endmodule

// ===== rtl/core/i2cdw_checker.sv =====
// i2cdw_checker: port-level assertions on the result channel of the top level.
// Bound to i2c_display_write_master_unit; no package dependency.
module i2cdw_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic scl,
  input logic sda_out,
  input logic sda_drive,
  input logic busy_res,
  input logic done_res,
  input logic addr_nack
);

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_res |-> !busy_res)
    else $error("done beat reports busy");

  a_nack_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && addr_nack |-> done_res)
    else $error("address nack without done");

  a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !busy_res |-> scl && sda_out && sda_drive)
    else $error("idle beat with bus not released high");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(scl) && $stable(sda_out)
      && $stable(sda_drive) && $stable(busy_res) && $stable(done_res))
    else $error("stalled result beat changed");

endmodule

bind i2c_display_write_master_unit i2cdw_checker u_i2cdw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .scl       (out_bus.scl),
  .sda_out   (out_bus.sda_out),
  .sda_drive (out_bus.sda_drive),
  .busy_res  (out_bus.busy_res),
  .done_res  (out_bus.done_res),
  .addr_nack (out_bus.addr_nack)
);
